// ----- rtl/nef_pkg.sv -----
// ----------------------------------------------------------------------------
// nef_pkg
// Shared constants for the nonlinear extremum filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nef_pkg;

  // Default sample width, two's complement
  localparam int SampleBitsDef = 24;

  // Filter weight: unsigned Q1.15
  localparam int WeightBits = 16;
  localparam logic [WeightBits-1:0] WeightOne = 16'h8000;

  // Most results one accepted item can release (final sample of a vector)
  localparam int PushMax = 3;

endpackage : nef_pkg

`default_nettype wire

// ----- rtl/nef_sample_if.sv -----
// ----------------------------------------------------------------------------
// nef_sample_if
// Input channel: one vector element and its end marker per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface nef_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          is_last;

  modport source (output valid, output sample, output is_last, input ready);
  modport sink   (input valid, input sample, input is_last, output ready);
endinterface : nef_sample_if

`default_nettype wire

// ----- rtl/nef_result_if.sv -----
// ----------------------------------------------------------------------------
// nef_result_if
// Output channel: one filtered element and its end marker per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface nef_result_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] filtered;
  logic                          end_of_vector;

  modport source (output valid, output filtered, output end_of_vector, input ready);
  modport sink   (input valid, input filtered, input end_of_vector, output ready);
endinterface : nef_result_if

`default_nettype wire

// ----- rtl/nef_cfg_if.sv -----
// ----------------------------------------------------------------------------
// nef_cfg_if
// Configuration write channel for the weight register.
// ----------------------------------------------------------------------------
`default_nettype none

interface nef_cfg_if
  import nef_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [WeightBits-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : nef_cfg_if

`default_nettype wire

// ----- rtl/nef_window.sv -----
// ----------------------------------------------------------------------------
// nef_window
// Extremum test and adjustment over one three-sample window.
// ----------------------------------------------------------------------------
`default_nettype none

module nef_window
  import nef_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  wire logic        [WeightBits-1:0]  weight_i,
  input  wire logic signed [SAMPLE_BITS-1:0] a_i,
  input  wire logic signed [SAMPLE_BITS-1:0] b_i,
  input  wire logic signed [SAMPLE_BITS-1:0] c_i,
  output logic signed      [SAMPLE_BITS-1:0] a_o,
  output logic signed      [SAMPLE_BITS-1:0] b_o,
  output logic signed      [SAMPLE_BITS-1:0] c_o
);

  localparam int DW = SAMPLE_BITS + 1;   // difference
  localparam int PW = SAMPLE_BITS + 18;  // product with weight
  localparam int EW = SAMPLE_BITS + 2;   // correction
  localparam int RW = SAMPLE_BITS + 3;   // adjusted value before clipping

  localparam logic signed [RW-1:0] SatHi = {{(RW-SAMPLE_BITS+1){1'b0}},
                                            {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RW-1:0] SatLo = ~SatHi;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [RW-1:0] x);
    logic signed [RW-1:0] y;
    y = (x > SatHi) ? SatHi : ((x < SatLo) ? SatLo : x);
    return y[SAMPLE_BITS-1:0];
  endfunction

  logic signed [DW-1:0] dp, dm, steep, shallow;
  logic                 pos, neg, extremum, steep_right;
  logic signed [16:0]   w_s;
  logic signed [PW-1:0] prod_st, prod_sh;
  logic signed [EW-1:0] ep, em, e;
  logic signed [RW-1:0] a_adj, b_adj, c_adj;

  assign dp = DW'(c_i) - DW'(b_i);
  assign dm = DW'(a_i) - DW'(b_i);

  assign pos      = (dp > 0) && (dm > 0);
  assign neg      = (dp < 0) && (dm < 0);
  assign extremum = pos || neg;

  // Steeper side on the right: move c, otherwise (ties too) move a
  assign steep_right = pos ? (dp > dm) : (dp < dm);
  assign steep       = steep_right ? dp : dm;
  assign shallow     = steep_right ? dm : dp;

  assign w_s     = $signed({1'b0, weight_i});
  assign prod_st = steep * w_s;
  assign prod_sh = shallow * w_s;

  // Floor shifts: half the steep step, full shallow step
  assign ep = prod_st[16 +: EW];
  assign em = prod_sh[15 +: EW];

  // Both share the sign of the differences; keep the smaller magnitude
  assign e = pos ? ((ep < em) ? ep : em) : ((ep > em) ? ep : em);

  assign a_adj = RW'(a_i) - RW'(e);
  assign b_adj = RW'(b_i) + RW'(e);
  assign c_adj = RW'(c_i) - RW'(e);

  assign a_o = (extremum && !steep_right) ? sat(a_adj) : a_i;
  assign b_o = extremum ? sat(b_adj) : b_i;
  assign c_o = (extremum && steep_right) ? sat(c_adj) : c_i;

endmodule : nef_window

`default_nettype wire

// ----- rtl/nef_outq.sv -----
// ----------------------------------------------------------------------------
// nef_outq
// Result queue: takes up to three items a cycle, releases one a cycle while out_o.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module nef_outq
  import nef_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [1:0]               push_cnt_i,
  input  wire logic [SAMPLE_BITS:0]     push_data_i [PushMax],
  output logic                          space_ok_o,
  nef_result_if.source                  out_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  logic [SAMPLE_BITS:0] entry_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 pop;

  assign pop        = out_o.valid && out_o.ready;
  assign space_ok_o = cnt_q <= CntW'(Depth - PushMax);

  assign out_o.valid         = cnt_q != '0;
  assign out_o.filtered      = entry_q[rd_ptr_q][SAMPLE_BITS-1:0];
  assign out_o.end_of_vector = entry_q[rd_ptr_q][SAMPLE_BITS];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PushMax; k++) begin
      if (2'(k) < push_cnt_i) begin
        entry_q[wr_ptr_q + PtrW'(k)] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_cnt_i);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_cnt_i) - CntW'(pop);
    end
  end

endmodule : nef_outq

`default_nettype wire

// ----- rtl/nonlinear_extremum_filter.sv -----
// ----------------------------------------------------------------------------
// nonlinear_extremum_filter
// Streaming filter that pulls local extrema of a vector toward the steeper
// neighbour, with a weight register in Q1.15.
// ----------------------------------------------------------------------------
// Results are registered in the result queue before they show on out_o.
// Throughput: one item per cycle while the output side keeps up; the final
//   sample of a vector frees up to three results, drained one per cycle.
// in_i.ready drops while the result queue holds two or more items.
// Reset: empty window, empty queue, weight at 1.0 (32768).
// ----------------------------------------------------------------------------
`default_nettype none

module nonlinear_extremum_filter
  import nef_pkg::*;
#(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  nef_cfg_if.sink       cfg_i,
  nef_sample_if.sink    in_i,
  nef_result_if.source  out_o
);

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_ONE,
    HELD_TWO
  } held_e;

  // Weight register, clipped to 1.0 on write
  logic [WeightBits-1:0] weight_q;

  // Window: older (a) and newer (b) held samples; the arriving sample is c
  logic signed [SAMPLE_BITS-1:0] older_q, older_d;
  logic signed [SAMPLE_BITS-1:0] newer_q, newer_d;
  held_e                         held_q, held_d, held_next;

  logic signed [SAMPLE_BITS-1:0] a_w, b_w, c_w;
  logic                          accept, space_ok;
  logic [1:0]                    push_cnt, push_cnt_raw;
  logic [SAMPLE_BITS:0]          push_data [PushMax];

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = space_ok;
  assign accept      = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WeightOne;
    end else if (cfg_i.valid) begin
      weight_q <= (cfg_i.data > WeightOne) ? WeightOne : cfg_i.data;
    end
  end

  nef_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .weight_i (weight_q),
    .a_i      (older_q),
    .b_i      (newer_q),
    .c_i      (in_i.sample),
    .a_o      (a_w),
    .b_o      (b_w),
    .c_o      (c_w)
  );

  // Advance the window and collect the results this item frees, in order.
  always_comb begin
    older_d      = older_q;
    newer_d      = newer_q;
    held_next    = held_q;
    push_cnt_raw = '0;
    for (int k = 0; k < PushMax; k++) begin
      push_data[k] = '0;
    end

    case (held_q)
      HELD_TWO: begin
        // Oldest sample can no longer change: release it
        push_data[0] = {1'b0, a_w};
        push_cnt_raw = 2'd1;
        older_d      = b_w;
        newer_d      = c_w;
        held_next    = HELD_TWO;
      end
      HELD_ONE: begin
        older_d   = newer_q;
        newer_d   = in_i.sample;
        held_next = HELD_TWO;
      end
      default: begin
        newer_d   = in_i.sample;
        held_next = HELD_ONE;
      end
    endcase

    held_d = held_next;
    if (in_i.is_last) begin
      // Flush the window and return it to empty
      if (held_next == HELD_TWO) begin
        push_data[push_cnt_raw] = {1'b0, older_d};
        push_cnt_raw            = push_cnt_raw + 2'd1;
      end
      push_data[push_cnt_raw] = {1'b1, newer_d};
      push_cnt_raw            = push_cnt_raw + 2'd1;
      older_d                 = '0;
      newer_d                 = '0;
      held_d                  = HELD_NONE;
    end
  end

  assign push_cnt = accept ? push_cnt_raw : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q <= '0;
      newer_q <= '0;
      held_q  <= HELD_NONE;
    end else if (accept) begin
      older_q <= older_d;
      newer_q <= newer_d;
      held_q  <= held_d;
    end
  end

  nef_outq #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push_data_i (push_data),
    .space_ok_o  (space_ok),
    .out_o       (out_o)
  );

endmodule : nonlinear_extremum_filter

`default_nettype wire
